// File: design/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, codes and move table for the leaper tour step engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

  localparam int LTS_MAX_SIDE = 8;
  localparam int LTS_MOVES    = 24;
  localparam int MOVE_W       = $clog2(LTS_MOVES + 1);

  localparam int POS_W   = 3;
  localparam int STEP_W  = 10;
  localparam int STAT_W  = 3;
  localparam int DEG_W   = 5;
  localparam int BSIZE_W = 4;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 4'd8;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_MOVED     = 3'd0,
    STAT_COMPLETE  = 3'd1,
    STAT_STUCK     = 3'd2,
    STAT_BAD_START = 3'd3,
    STAT_NO_TOUR   = 3'd4
  } lts_status_t;

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] start_x;
    logic [POS_W-1:0] start_y;
    logic [POS_W-1:0] start_z;
  } lts_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [STEP_W-1:0] step_number;
    logic [STAT_W-1:0] status;
  } lts_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SWEEP,
    S_MARK,
    S_UPDATE,
    S_SEARCH,
    S_PICK,
    S_FINISH
  } lts_state_t;

  // Result selection, issued by the controller once a command is resolved.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_BAD_START,
    RES_NOT_RUNNING,
    RES_STUCK,
    RES_VISITED
  } lts_res_t;

  typedef struct packed {
    logic     load_in;
    logic     latch_side;
    logic     set_start;
    logic     sweep_clr;
    logic     sweep_en;
    logic     mark;
    logic     take_best;
    logic     scan_clr;
    logic     scan_en;
    logic     search_eval;
    logic     update_eval;
    lts_res_t res_sel;
    logic     out_load;
  } lts_cmd_t;

  typedef struct packed {
    logic cmd_step;
    logic start_bad;
    logic running;
    logic sweep_last;
    logic scan_last;
    logic found;
    logic out_free;
  } lts_stat_t;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
    logic signed [2:0] dz;
  } lts_off_t;

  // Move order: base (2,2,1), (2,1,2), (1,2,2); sign bits a,b,c from bit 2 down.
  function automatic lts_off_t lts_move_offset(input logic [MOVE_W-1:0] m);
    logic signed [2:0] ba;
    logic signed [2:0] bb;
    logic signed [2:0] bc;
    lts_off_t          o;
    unique case (m[4:3])
      2'd0: begin
        ba = 3'sd2; bb = 3'sd2; bc = 3'sd1;
      end
      2'd1: begin
        ba = 3'sd2; bb = 3'sd1; bc = 3'sd2;
      end
      default: begin
        ba = 3'sd1; bb = 3'sd2; bc = 3'sd2;
      end
    endcase
    o.dx = m[2] ? ba : -ba;
    o.dy = m[1] ? bb : -bb;
    o.dz = m[0] ? bc : -bc;
    return o;
  endfunction

endpackage

`default_nettype wire

// File: design/lts_ctrl.sv
// ----------------------------------------------------------------------------
// lts_ctrl
// Command sequencer: decode, degree sweep, neighbor search and update scans.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_ctrl
  import lts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire lts_stat_t stat,
  output lts_cmd_t       cmd
);

  lts_state_t state_r;
  lts_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!stat.cmd_step) begin
          state_nxt = stat.start_bad ? S_FINISH : S_SWEEP;
        end else begin
          state_nxt = stat.running ? S_SEARCH : S_FINISH;
        end
      end
      S_SWEEP: begin
        if (stat.sweep_last) state_nxt = S_MARK;
      end
      S_MARK:   state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (stat.scan_last) state_nxt = S_FINISH;
      end
      S_SEARCH: begin
        if (stat.scan_last) state_nxt = S_PICK;
      end
      S_PICK:   state_nxt = stat.found ? S_MARK : S_FINISH;
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res_sel = RES_NONE;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        if (!stat.cmd_step) begin
          if (stat.start_bad) begin
            cmd.res_sel = RES_BAD_START;
          end else begin
            cmd.latch_side = 1'b1;
            cmd.set_start  = 1'b1;
            cmd.sweep_clr  = 1'b1;
          end
        end else if (stat.running) begin
          cmd.scan_clr = 1'b1;
        end else begin
          cmd.res_sel = RES_NOT_RUNNING;
        end
      end
      S_SWEEP: begin
        cmd.sweep_en = 1'b1;
      end
      S_MARK: begin
        cmd.mark     = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      S_UPDATE: begin
        cmd.scan_en     = 1'b1;
        cmd.update_eval = 1'b1;
        if (stat.scan_last) cmd.res_sel = RES_VISITED;
      end
      S_SEARCH: begin
        cmd.scan_en     = 1'b1;
        cmd.search_eval = 1'b1;
      end
      S_PICK: begin
        if (stat.found) begin
          cmd.take_best = 1'b1;
        end else begin
          cmd.res_sel = RES_STUCK;
        end
      end
      S_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd.res_sel = RES_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/lts_datapath.sv
// ----------------------------------------------------------------------------
// lts_datapath
// Visited and degree memories, tour position, neighbor scan pipeline, result.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_datapath
  import lts_pkg::*;
#(
  parameter int MAX_SIDE = LTS_MAX_SIDE
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [BSIZE_W-1:0] cfg_wr_data,
  input  wire lts_in_t            in_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output lts_out_t                out_data,
  input  wire lts_cmd_t           cmd,
  output lts_stat_t               stat
);

  localparam int CW      = $clog2(MAX_SIDE);
  localparam int SW      = $clog2(MAX_SIDE + 1);
  localparam int NW      = CW + 2;
  localparam int AW      = 3 * CW;
  localparam int DEPTH   = 2 ** AW;
  localparam int SQW     = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int STW     = $clog2(MAX_SIDE * MAX_SIDE * MAX_SIDE + 1);
  localparam int POS_XW  = (CW > POS_W) ? CW : POS_W;
  localparam int STEP_XW = (STW > STEP_W) ? STW : STEP_W;

  // Number of in-range positions at distance d along one axis.
  function automatic logic [1:0] axis_cnt(input logic [CW-1:0] v,
                                          input logic [SW-1:0] s,
                                          input logic [1:0]    d);
    logic [SW:0] ve;
    ve = (SW + 1)'(v) + (SW + 1)'(d);
    return 2'(v >= CW'(d)) + 2'(ve < (SW + 1)'(s));
  endfunction

  logic             vis_mem [DEPTH];
  logic [DEG_W-1:0] deg_mem [DEPTH];

  logic [BSIZE_W-1:0] board_size_r;
  lts_in_t            in_r;
  logic [SW-1:0]      side_r;
  logic [SQW-1:0]     sq_r;
  logic [STW-1:0]     total_r;
  logic [CW-1:0]      cur_x_r, cur_y_r, cur_z_r;
  logic [STW-1:0]     step_r;
  logic               running_r;
  logic [AW-1:0]      sweep_cnt_r;
  logic [MOVE_W-1:0]  move_r;
  logic               ev_valid_r;
  logic               ev_in_r;
  logic [CW-1:0]      ev_x_r, ev_y_r, ev_z_r;
  logic               vis_rd_r;
  logic [DEG_W-1:0]   deg_rd_r;
  logic               found_r;
  logic [DEG_W-1:0]   best_deg_r;
  logic [CW-1:0]      best_x_r, best_y_r, best_z_r;
  lts_out_t           res_r;
  logic               out_valid_r;
  lts_out_t           out_data_r;

  logic [SW-1:0]       side_clamp;
  logic                start_bad;
  lts_off_t            off;
  logic signed [NW-1:0] nx_s, ny_s, nz_s, side_s;
  logic                nb_in;
  logic                issue;
  logic [AW-1:0]       rd_addr, cur_addr, ev_addr;
  logic [1:0]          n1x, n1y, n1z, n2x, n2y, n2z;
  logic [DEG_W-1:0]    sweep_deg;
  logic                cand;
  logic                upd_we;
  logic                vis_we, deg_we;
  logic [AW-1:0]       vis_wa, deg_wa;
  logic                vis_wd;
  logic [DEG_W-1:0]    deg_wd;
  logic                done;
  logic [POS_XW-1:0]   px_ext, py_ext, pz_ext;
  logic [STEP_XW-1:0]  step_ext;

  // Side clamp and start cell check.
  always_comb begin
    if (board_size_r == '0) begin
      side_clamp = SW'(1);
    end else if (32'(board_size_r) > 32'(MAX_SIDE)) begin
      side_clamp = SW'(MAX_SIDE);
    end else begin
      side_clamp = SW'(board_size_r);
    end
    start_bad = (32'(in_r.start_x) >= 32'(side_clamp)) ||
                (32'(in_r.start_y) >= 32'(side_clamp)) ||
                (32'(in_r.start_z) >= 32'(side_clamp));
  end

  // Neighbor of the current cell for the move being issued.
  always_comb begin
    off    = lts_move_offset(move_r);
    nx_s   = $signed(NW'(cur_x_r)) + NW'(off.dx);
    ny_s   = $signed(NW'(cur_y_r)) + NW'(off.dy);
    nz_s   = $signed(NW'(cur_z_r)) + NW'(off.dz);
    side_s = $signed(NW'(side_r));
    nb_in  = (nx_s >= 0) && (nx_s < side_s) &&
             (ny_s >= 0) && (ny_s < side_s) &&
             (nz_s >= 0) && (nz_s < side_s);
    issue    = cmd.scan_en && (move_r < MOVE_W'(LTS_MOVES));
    rd_addr  = {nx_s[CW-1:0], ny_s[CW-1:0], nz_s[CW-1:0]};
    cur_addr = {cur_x_r, cur_y_r, cur_z_r};
    ev_addr  = {ev_x_r, ev_y_r, ev_z_r};
  end

  // Initial degree of the cell under the sweep counter.
  always_comb begin
    n1x = axis_cnt(sweep_cnt_r[3*CW-1:2*CW], side_r, 2'd1);
    n1y = axis_cnt(sweep_cnt_r[2*CW-1:CW],   side_r, 2'd1);
    n1z = axis_cnt(sweep_cnt_r[CW-1:0],      side_r, 2'd1);
    n2x = axis_cnt(sweep_cnt_r[3*CW-1:2*CW], side_r, 2'd2);
    n2y = axis_cnt(sweep_cnt_r[2*CW-1:CW],   side_r, 2'd2);
    n2z = axis_cnt(sweep_cnt_r[CW-1:0],      side_r, 2'd2);
    sweep_deg = DEG_W'(n2x) * DEG_W'(n2y) * DEG_W'(n1z) +
                DEG_W'(n2x) * DEG_W'(n1y) * DEG_W'(n2z) +
                DEG_W'(n1x) * DEG_W'(n2y) * DEG_W'(n2z);
  end

  // Evaluation stage: one move behind the issue.
  always_comb begin
    cand   = ev_valid_r && ev_in_r && !vis_rd_r;
    upd_we = cmd.update_eval && cand && (deg_rd_r != '0);
    vis_we = cmd.sweep_en || cmd.mark;
    vis_wa = cmd.sweep_en ? sweep_cnt_r : cur_addr;
    vis_wd = cmd.mark;
    deg_we = cmd.sweep_en || upd_we;
    deg_wa = cmd.sweep_en ? sweep_cnt_r : ev_addr;
    deg_wd = cmd.sweep_en ? sweep_deg : (deg_rd_r - DEG_W'(1));
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    vis_rd_r <= vis_mem[rd_addr];
    deg_rd_r <= deg_mem[rd_addr];
  end

  // Result fields.
  always_comb begin
    done     = (step_r >= total_r);
    px_ext   = POS_XW'(cur_x_r);
    py_ext   = POS_XW'(cur_y_r);
    pz_ext   = POS_XW'(cur_z_r);
    step_ext = STEP_XW'(step_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= BSIZE_RESET;
      side_r       <= SW'(1);
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      cur_z_r      <= '0;
      step_r       <= '0;
      running_r    <= 1'b0;
      sweep_cnt_r  <= '0;
      move_r       <= '0;
      ev_valid_r   <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) board_size_r <= cfg_wr_data;
      if (cmd.latch_side) side_r <= side_clamp;

      if (cmd.set_start) begin
        cur_x_r <= CW'(in_r.start_x);
        cur_y_r <= CW'(in_r.start_y);
        cur_z_r <= CW'(in_r.start_z);
        step_r  <= STW'(1);
      end else if (cmd.take_best) begin
        cur_x_r <= best_x_r;
        cur_y_r <= best_y_r;
        cur_z_r <= best_z_r;
        step_r  <= STW'(step_r + STW'(1));
      end

      if (cmd.sweep_clr) begin
        sweep_cnt_r <= '0;
      end else if (cmd.sweep_en) begin
        sweep_cnt_r <= sweep_cnt_r + AW'(1);
      end

      if (cmd.scan_clr) begin
        move_r <= '0;
      end else if (issue) begin
        move_r <= move_r + MOVE_W'(1);
      end
      ev_valid_r <= issue;

      if (cmd.scan_clr) begin
        found_r <= 1'b0;
      end else if (cmd.search_eval && cand && (!found_r || (deg_rd_r < best_deg_r))) begin
        found_r <= 1'b1;
      end

      unique case (cmd.res_sel)
        RES_BAD_START:   running_r <= 1'b0;
        RES_STUCK:       running_r <= 1'b0;
        RES_VISITED:     running_r <= !done;
        RES_NOT_RUNNING: running_r <= running_r;
        RES_NONE:        running_r <= running_r;
        default:         running_r <= running_r;
      endcase

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    sq_r    <= SQW'(SQW'(side_r) * SQW'(side_r));
    total_r <= STW'(STW'(sq_r) * STW'(side_r));
    ev_in_r <= nb_in;
    ev_x_r  <= nx_s[CW-1:0];
    ev_y_r  <= ny_s[CW-1:0];
    ev_z_r  <= nz_s[CW-1:0];
    if (cmd.search_eval && cand && (!found_r || (deg_rd_r < best_deg_r))) begin
      best_deg_r <= deg_rd_r;
      best_x_r   <= ev_x_r;
      best_y_r   <= ev_y_r;
      best_z_r   <= ev_z_r;
    end
    unique case (cmd.res_sel)
      RES_BAD_START: begin
        res_r.pos_x       <= in_r.start_x;
        res_r.pos_y       <= in_r.start_y;
        res_r.pos_z       <= in_r.start_z;
        res_r.step_number <= '0;
        res_r.status      <= STAT_BAD_START;
      end
      RES_NOT_RUNNING, RES_STUCK, RES_VISITED: begin
        res_r.pos_x       <= px_ext[POS_W-1:0];
        res_r.pos_y       <= py_ext[POS_W-1:0];
        res_r.pos_z       <= pz_ext[POS_W-1:0];
        res_r.step_number <= step_ext[STEP_W-1:0];
        if (cmd.res_sel == RES_NOT_RUNNING) begin
          res_r.status <= STAT_NO_TOUR;
        end else if (cmd.res_sel == RES_STUCK) begin
          res_r.status <= STAT_STUCK;
        end else begin
          res_r.status <= done ? STAT_COMPLETE : STAT_MOVED;
        end
      end
      RES_NONE: res_r <= res_r;
      default:  res_r <= res_r;
    endcase
    if (cmd.out_load) out_data_r <= res_r;
  end

  always_comb begin
    stat.cmd_step   = (in_r.cmd == CMD_STEP);
    stat.start_bad  = start_bad;
    stat.running    = running_r;
    stat.sweep_last = &sweep_cnt_r;
    stat.scan_last  = (move_r == MOVE_W'(LTS_MOVES));
    stat.found      = found_r;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: design/leaper_tour_min_degree_step.sv
// ----------------------------------------------------------------------------
// leaper_tour_min_degree_step
// Min-degree (Warnsdorff) tour of a cube with the 24 (2,2,1) leaper moves.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one transaction per command,
//    cmd 0 starts a tour at start_x/y/z, cmd 1 advances one move.
//  - Output channel (out_valid/out_stall/out_data): exactly one transaction
//    per command: position, step number and status.
//  - cfg_wr_en/cfg_wr_data write board_size; the side is clamped and latched
//    at each good start. Write only while the block is idle.
//  - A step while running decodes, scans the 24 moves for the free neighbor
//    of least degree (one memory read per cycle), picks and marks it and
//    rescans to update degrees; a start sweeps all 2^(3*clog2(MAX_SIDE))
//    degree-store cells, then marks and updates; a bad start or a step
//    with no tour goes from decode to finish. One command in flight; the
//    next is taken the cycle after the result is registered.
//  - Output register decouples the sides: a stalled result holds while the
//    next command is accepted; its result waits in the finish state.
//  - Reset: no tour running, position and step count zero, board_size 8.
//    Maps need no clearing at reset since a start rebuilds them.
// ----------------------------------------------------------------------------
`default_nettype none

module leaper_tour_min_degree_step
  import lts_pkg::*;
#(
  parameter int MAX_SIDE = LTS_MAX_SIDE
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [BSIZE_W-1:0] cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lts_in_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lts_out_t                out_data
);

  // command and status between sequencer and datapath
  lts_cmd_t  cmd;
  lts_stat_t stat;

  lts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories, scan pipeline and the output register live here
  lts_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire

// File: design/lts_checker.sv
// ----------------------------------------------------------------------------
// lts_checker
// Port-level checks of the tour step engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_checker
  import lts_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire lts_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lts_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one command in flight: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in flight");

  // a step command does not raise out_valid straight after it is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd == CMD_STEP |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_bad_start_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_BAD_START |-> out_data.step_number == '0)
    else $error("bad start with nonzero step number");

  a_moved_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_MOVED || out_data.status == STAT_COMPLETE)
      |-> out_data.step_number != '0)
    else $error("visited cell with step number zero");

endmodule

bind leaper_tour_min_degree_step lts_checker u_lts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
